>>> sv/imusfd_pkg.sv
// Package for the IMU serial frame decoder: frame codes, scale factors and the
// item types that move between the front end, the scaling back end and the queues.
// Depends on nothing.
package imusfd_pkg;

	localparam int BYTE_W  = 8;
	localparam int RAW_W   = 16;
	localparam int AXIS_W  = 20;
	localparam int SCALE_W = 20;
	localparam int CNT_W   = 4;
	localparam int PROD_W  = RAW_W + SCALE_W + 1;
	localparam int FRAC_SHIFT = 15;
	localparam int DATA_BYTES = 6;
	localparam int DATA_FIRST = 2;

	localparam logic [BYTE_W-1:0] HDR_BYTE = 8'h55;
	localparam logic [BYTE_W-1:0] TYPE_ACC = 8'h51;
	localparam logic [BYTE_W-1:0] TYPE_GYR = 8'h52;
	localparam logic [BYTE_W-1:0] TYPE_ANG = 8'h53;

	localparam logic [SCALE_W-1:0] SCALE_ACC = 20'd40141;
	localparam logic [SCALE_W-1:0] SCALE_GYR = 20'd512000;
	localparam logic [SCALE_W-1:0] SCALE_ANG = 20'd46080;

	typedef enum logic [1:0] {
		KIND_ACC = 2'd0,
		KIND_GYR = 2'd1,
		KIND_ANG = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                   kind;
		logic signed [RAW_W-1:0] raw_x;
		logic signed [RAW_W-1:0] raw_y;
		logic signed [RAW_W-1:0] raw_z;
	} imusfd_item_t;

	typedef struct packed {
		kind_t                    kind;
		logic signed [AXIS_W-1:0] axis_x;
		logic signed [AXIS_W-1:0] axis_y;
		logic signed [AXIS_W-1:0] axis_z;
	} imusfd_result_t;

endpackage

>>> sv/imusfd_fifo.sv
// Small generic first-in first-out queue with a show-ahead head entry.
// Depends on nothing; used for the decoded-frame queue and the result queue.
module imusfd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> sv/imusfd_front.sv
// Front end: hunts for the frame header, collects frame bytes and classifies
// complete frames by type. Depends on imusfd_pkg.
module imusfd_front
	import imusfd_pkg::*;
#(
	parameter int FRAME_LEN = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [BYTE_W-1:0]  rx_byte,
	output logic               item_push,
	output imusfd_item_t       item
);

	localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_LEN - 1);

	logic [CNT_W-1:0]  count_q;
	logic [BYTE_W-1:0] type_q;
	logic [BYTE_W-1:0] data_q [DATA_BYTES];
	logic [BYTE_W-1:0] data_now [DATA_BYTES];
	logic              type_known;
	kind_t             kind;

	// The final byte may itself carry data when frames are short, so the
	// current byte is forwarded into its data slot.
	always_comb begin
		for (int i = 0; i < DATA_BYTES; i++) begin
			data_now[i] = (count_q == CNT_W'(i + DATA_FIRST)) ? rx_byte : data_q[i];
		end
	end

	always_comb begin
		type_known = 1'b1;
		kind       = KIND_ACC;
		case (type_q)
			TYPE_ACC: kind = KIND_ACC;
			TYPE_GYR: kind = KIND_GYR;
			TYPE_ANG: kind = KIND_ANG;
			default:  type_known = 1'b0;
		endcase
	end

	assign item_push  = accept && (count_q == LAST_POS) && type_known;
	assign item.kind  = kind;
	assign item.raw_x = $signed({data_now[1], data_now[0]});
	assign item.raw_y = $signed({data_now[3], data_now[2]});
	assign item.raw_z = $signed({data_now[5], data_now[4]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (count_q == '0) begin
				if (rx_byte == HDR_BYTE) begin
					count_q <= CNT_W'(1);
				end
			end else if (count_q == LAST_POS) begin
				count_q <= '0;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (count_q == CNT_W'(1)) begin
				type_q <= rx_byte;
			end
			for (int i = 0; i < DATA_BYTES; i++) begin
				if (count_q == CNT_W'(i + DATA_FIRST)) begin
					data_q[i] <= rx_byte;
				end
			end
		end
	end

endmodule

>>> sv/imusfd_back.sv
// Back end: takes classified frames from the queue, multiplies each raw axis by
// its type's scale and drops 15 fraction bits. Depends on imusfd_pkg.
module imusfd_back
	import imusfd_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  imusfd_item_t   item,
	input  logic           item_empty,
	output logic           item_pop,
	output logic           res_push,
	output imusfd_result_t res,
	input  logic           res_full
);

	logic [SCALE_W-1:0]       scale;
	logic                     valid_s1;
	kind_t                    kind_s1;
	logic signed [PROD_W-1:0] prod_x_s1;
	logic signed [PROD_W-1:0] prod_y_s1;
	logic signed [PROD_W-1:0] prod_z_s1;
	logic signed [SCALE_W:0]  scale_s;
	logic                     s1_ready;

	always_comb begin
		case (item.kind)
			KIND_ACC: scale = SCALE_ACC;
			KIND_GYR: scale = SCALE_GYR;
			KIND_ANG: scale = SCALE_ANG;
			default:  scale = SCALE_ACC;
		endcase
	end

	assign scale_s  = $signed({1'b0, scale});
	assign res_push = valid_s1 && !res_full;
	assign s1_ready = !valid_s1 || !res_full;
	assign item_pop = !item_empty && s1_ready;

	// An arithmetic shift by 15 rounds toward minus infinity; the result fits 20 bits.
	assign res.kind   = kind_s1;
	assign res.axis_x = prod_x_s1[FRAC_SHIFT +: AXIS_W];
	assign res.axis_y = prod_y_s1[FRAC_SHIFT +: AXIS_W];
	assign res.axis_z = prod_z_s1[FRAC_SHIFT +: AXIS_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= item_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			kind_s1   <= item.kind;
			prod_x_s1 <= item.raw_x * scale_s;
			prod_y_s1 <= item.raw_y * scale_s;
			prod_z_s1 <= item.raw_z * scale_s;
		end
	end

endmodule

>>> sv/imu_serial_frame_decoder_core.sv
// IMU serial frame decoder: one received byte per cycle in while full is low, one scaled
// result out per frame of a known type. Each result passes through the frame queue, the
// multiply register and the result queue; both queues absorb stalls on the output.
// Reset (arst_n low, asynchronous) empties both queues and restarts the header hunt.
// Depends on imusfd_pkg, imusfd_fifo, imusfd_front and imusfd_back.
module imu_serial_frame_decoder_core
	import imusfd_pkg::*;
#(
	parameter int FRAME_LEN   = 11,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [BYTE_W-1:0]        rx_byte,
	output logic                     empty,
	input  logic                     pop,
	output logic [1:0]               kind,
	output logic signed [AXIS_W-1:0] axis_x,
	output logic signed [AXIS_W-1:0] axis_y,
	output logic signed [AXIS_W-1:0] axis_z
);

	localparam int ITEM_W = $bits(imusfd_item_t);
	localparam int RES_W  = $bits(imusfd_result_t);

	// A byte is taken whenever the frame queue has room. Only the last byte of a
	// frame ever pushes into that queue, so checking its full flag is enough.
	logic           accept;
	logic           mid_push;
	logic           mid_full;
	logic           mid_empty;
	logic           mid_pop;
	imusfd_item_t   mid_wdata;
	imusfd_item_t   mid_rdata;
	logic [ITEM_W-1:0] mid_rdata_raw;

	logic           res_push;
	logic           res_full;
	imusfd_result_t res_wdata;
	imusfd_result_t res_rdata;
	logic [RES_W-1:0] res_rdata_raw;

	assign full   = mid_full;
	assign accept = push && !full;

	// The front end follows the frame position and emits a classified frame
	// with its three raw axis values when the last byte of a known type arrives.
	imusfd_front #(
		.FRAME_LEN (FRAME_LEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.item_push (mid_push),
		.item      (mid_wdata)
	);

	// Queue of classified frames between the front end and the scaler.
	imusfd_fifo #(
		.WIDTH (ITEM_W),
		.DEPTH (QUEUE_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata_raw),
		.empty  (mid_empty)
	);

	assign mid_rdata = imusfd_item_t'(mid_rdata_raw);

	// The back end holds one multiply stage with three constant-coefficient
	// products, then hands the scaled values to the result queue.
	imusfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (mid_rdata),
		.item_empty (mid_empty),
		.item_pop   (mid_pop),
		.res_push   (res_push),
		.res        (res_wdata),
		.res_full   (res_full)
	);

	// Result queue: the oldest result sits on the output ports while empty is low.
	imusfd_fifo #(
		.WIDTH (RES_W),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata_raw),
		.empty  (empty)
	);

	assign res_rdata = imusfd_result_t'(res_rdata_raw);
	assign kind      = res_rdata.kind;
	assign axis_x    = res_rdata.axis_x;
	assign axis_y    = res_rdata.axis_y;
	assign axis_z    = res_rdata.axis_z;

	// A classified frame is never offered to a full frame queue.
	assert property (@(posedge clk) disable iff (!arst_n) mid_push |-> !mid_full)
		else $error("frame pushed into a full frame queue");

	// The scaler never pushes a result into a full result queue.
	assert property (@(posedge clk) disable iff (!arst_n) res_push |-> !res_full)
		else $error("result pushed into a full result queue");

	// The scaler only takes a frame that is present in the queue.
	assert property (@(posedge clk) disable iff (!arst_n) mid_pop |-> !mid_empty)
		else $error("frame popped from an empty frame queue");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for imu_serial_frame_decoder_core: it streams serial bytes through
// the push side and checks every decoded word that leaves through the pop side.
// Depends on imusfd_pkg and the decoder RTL only.
module tb_top
	import imusfd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_LEN   = 11;
	localparam int QUEUE_DEPTH = 4;
	// The drained-state wait has to outlast the output latency by a safe margin.
	localparam int SETTLE_CYCLES = 20;
	localparam int DRAIN_LIMIT   = 4000;
	localparam int RANDOM_BYTES  = 1550;
	// The long receiver hold-off starts once this many bytes have been taken.
	localparam int HOLD_START   = 300;
	localparam int HOLD_CYCLES  = 600;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     push = 1'b0;
	logic                     full;
	logic [BYTE_W-1:0]        rx_byte = '0;
	logic                     empty;
	logic                     pop = 1'b0;
	logic [1:0]               kind;
	logic signed [AXIS_W-1:0] axis_x;
	logic signed [AXIS_W-1:0] axis_y;
	logic signed [AXIS_W-1:0] axis_z;

	imu_serial_frame_decoder_core #(
		.FRAME_LEN  (FRAME_LEN),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.rx_byte(rx_byte),
		.empty  (empty),
		.pop    (pop),
		.kind   (kind),
		.axis_x (axis_x),
		.axis_y (axis_y),
		.axis_z (axis_z)
	);

	always #4 clk = ~clk;

	// Bytes still to be offered on the push side, filled once at time zero.
	logic [BYTE_W-1:0] byte_q[$];
	// Decoded words that the block owes us, oldest first.
	imusfd_result_t    scaled_results_q[$];
	int                error_count = 0;
	int                bytes_taken = 0;

	// Shadow of the frame assembler: position of the next byte and the bytes collected so far.
	int                frame_pos = 0;
	logic [BYTE_W-1:0] frame_store [FRAME_LEN];

	// Position tracker used while the stimulus is built, so that well-formed frames can be
	// lined up on a frame boundary even after noise or a truncated frame.
	int                gen_pos = 0;

	// Scaling is floor(raw * factor / 2^15); an arithmetic shift of the signed product gives
	// exactly that rounding toward minus infinity.
	function automatic logic signed [AXIS_W-1:0] scale_raw(input logic signed [RAW_W-1:0] raw,
			input logic [SCALE_W-1:0] factor);
		longint prod;
		longint shifted;
		prod    = longint'(raw) * longint'(factor);
		shifted = prod >>> FRAC_SHIFT;
		return shifted[AXIS_W-1:0];
	endfunction

	// Advances the shadow assembler by one accepted byte and records the word that a
	// completed frame of a known type produces.
	task automatic decode_byte(input logic [BYTE_W-1:0] b);
		imusfd_result_t     res;
		logic [SCALE_W-1:0] factor;
		logic               known;
		// Header hunt: anything but the header byte at the start of a frame is dropped.
		if (frame_pos == 0 && b != HDR_BYTE) begin
			return;
		end
		frame_store[frame_pos] = b;
		frame_pos++;
		if (frame_pos < FRAME_LEN) begin
			return;
		end
		// The frame is consumed here whatever its type byte says.
		frame_pos = 0;
		known     = 1'b1;
		factor    = '0;
		res       = '0;
		case (frame_store[1])
			TYPE_ACC: begin
				res.kind = KIND_ACC;
				factor   = SCALE_ACC;
			end
			TYPE_GYR: begin
				res.kind = KIND_GYR;
				factor   = SCALE_GYR;
			end
			TYPE_ANG: begin
				res.kind = KIND_ANG;
				factor   = SCALE_ANG;
			end
			default: known = 1'b0;
		endcase
		if (known) begin
			res.axis_x = scale_raw({frame_store[3], frame_store[2]}, factor);
			res.axis_y = scale_raw({frame_store[5], frame_store[4]}, factor);
			res.axis_z = scale_raw({frame_store[7], frame_store[6]}, factor);
			scaled_results_q.push_back(res);
		end
	endtask

	task automatic queue_byte(input logic [BYTE_W-1:0] b);
		byte_q.push_back(b);
		if (gen_pos == 0 && b != HDR_BYTE) begin
			return;
		end
		gen_pos = (gen_pos + 1 == FRAME_LEN) ? 0 : gen_pos + 1;
	endtask

	// Queues one complete frame with little-endian raw values and random checksum bytes.
	// A frame left open by earlier bytes is finished with random filler first, so the new
	// frame starts on a boundary.
	task automatic queue_frame(input logic [BYTE_W-1:0] ftype, input logic [RAW_W-1:0] x,
			input logic [RAW_W-1:0] y, input logic [RAW_W-1:0] z);
		while (gen_pos != 0) begin
			queue_byte(BYTE_W'($urandom_range(0, 255)));
		end
		queue_byte(HDR_BYTE);
		queue_byte(ftype);
		queue_byte(x[7:0]);
		queue_byte(x[15:8]);
		queue_byte(y[7:0]);
		queue_byte(y[15:8]);
		queue_byte(z[7:0]);
		queue_byte(z[15:8]);
		for (int i = 8; i < FRAME_LEN; i++) begin
			queue_byte(BYTE_W'($urandom_range(0, 255)));
		end
	endtask

	// Raw sample values lean toward the extremes and toward values around zero now and then; the rest are uniform.
	function automatic logic [RAW_W-1:0] random_raw();
		case ($urandom_range(0, 11))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0001;
			4: return 16'h0000;
			default: return RAW_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// Sender: bytes go out in bursts of random length separated by random gaps. A gap of
	// zero joins two bursts, which gives long back-to-back stretches. While full holds an
	// offered byte back, the byte and push stay as they are.
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk) begin : drive_proc
		logic next_push;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				decode_byte(rx_byte);
				bytes_taken <= bytes_taken + 1;
			end
			if (!(push && full)) begin
				next_push = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (byte_q.size() > 0) begin
					next_push = 1'b1;
					rx_byte   <= byte_q.pop_front();
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 48);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
				push <= next_push;
			end
		end
	end

	// One long hold-off on the receive side, counted here in its own process. The sender
	// keeps going meanwhile, so the internal queues fill and full has to push back.
	logic rx_hold    = 1'b0;
	logic hold_used  = 1'b0;
	int   hold_count = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_count > 0) begin
				hold_count <= hold_count - 1;
				if (hold_count == 1) begin
					rx_hold <= 1'b0;
				end
			end else if (!hold_used && bytes_taken >= HOLD_START) begin
				rx_hold    <= 1'b1;
				hold_count <= HOLD_CYCLES;
				hold_used  <= 1'b1;
			end
		end
	end

	// Receiver: checks each popped word against the oldest expected one. Its stall pattern
	// walks through four modes in turn, chosen by bits 9:8 of its cycle count: always ready,
	// coin flip, a pop only when the low two bits of that count are zero, and mostly ready.
	int rx_cycle = 0;

	always @(posedge clk) begin : watch_proc
		imusfd_result_t want;
		logic           pop_next;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			rx_cycle++;
			if (pop && !empty) begin
				if (scaled_results_q.size() == 0) begin
					$error("unexpected word: kind %0d x %0d y %0d z %0d",
						kind, axis_x, axis_y, axis_z);
					error_count++;
				end else begin
					want = scaled_results_q.pop_front();
					if (kind !== want.kind) begin
						$error("kind: expected %0d, actual %0d", want.kind, kind);
						error_count++;
					end
					if (axis_x !== want.axis_x) begin
						$error("axis_x: expected %0d, actual %0d", want.axis_x, axis_x);
						error_count++;
					end
					if (axis_y !== want.axis_y) begin
						$error("axis_y: expected %0d, actual %0d", want.axis_y, axis_y);
						error_count++;
					end
					if (axis_z !== want.axis_z) begin
						$error("axis_z: expected %0d, actual %0d", want.axis_z, axis_z);
						error_count++;
					end
				end
			end
			case (rx_cycle[9:8])
				2'd0: pop_next = 1'b1;
				2'd1: pop_next = ($urandom_range(0, 1) == 1);
				2'd2: pop_next = (rx_cycle[1:0] == 2'd0);
				default: pop_next = ($urandom_range(0, 9) != 0);
			endcase
			pop <= rx_hold ? 1'b0 : pop_next;
		end
	end

	initial begin : main_proc
		int pick;
		int waited;
		// Directed part: two dropped noise bytes, one frame of each known type with the raw
		// extremes, and a frame whose type byte is the header value, which must give nothing.
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_frame(TYPE_ACC, 16'h8000, 16'h7FFF, 16'h0000);
		queue_frame(TYPE_GYR, 16'hFFFF, 16'h0001, 16'h8000);
		queue_frame(TYPE_ANG, 16'h7FFF, 16'h8000, 16'hFFFF);
		queue_frame(HDR_BYTE, 16'h1234, 16'hABCD, 16'h5555);

		// Random part: mostly well-formed frames of known type with random content; the rest
		// are noise runs, truncated frames and frames of arbitrary type.
		while (byte_q.size() < RANDOM_BYTES) begin
			pick = $urandom_range(0, 19);
			if (pick < 2) begin
				repeat ($urandom_range(1, 5)) queue_byte(BYTE_W'($urandom_range(0, 255)));
			end else if (pick == 2) begin
				if (gen_pos == 0) begin
					queue_byte(HDR_BYTE);
					repeat ($urandom_range(0, FRAME_LEN - 2))
						queue_byte(BYTE_W'($urandom_range(0, 255)));
				end
			end else if (pick == 3) begin
				queue_frame(BYTE_W'($urandom_range(0, 255)), random_raw(), random_raw(),
					random_raw());
			end else begin
				queue_frame(BYTE_W'($urandom_range(TYPE_ACC, TYPE_ANG)), random_raw(),
					random_raw(), random_raw());
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// All bytes taken, then every expected word delivered, then a quiet stretch that
		// would expose a word the block should not have produced. The sender's state is
		// looked at on the falling edge, after its updates at the rising edge have settled.
		do @(negedge clk); while (byte_q.size() != 0 || push);
		waited = 0;
		while (scaled_results_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (scaled_results_q.size() != 0) begin
			$error("%0d expected words never arrived", scaled_results_q.size());
			error_count++;
		end

		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog: the slowest legal run needs well under a tenth of this.
	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
